// ----- src/sfp_pkg.sv -----
`default_nettype none

package sfp_pkg;

   // Geometry of the sensor string
   localparam int ELEMENTS_PER_BOARD = 8;
   localparam int NUM_BOARDS         = 4;
   localparam int FRAME_BUFFER_BYTES = 25;
   localparam int NUM_ELEMENTS       = ELEMENTS_PER_BOARD * NUM_BOARDS;
   localparam int FRAME_LEN          = 1 + 2 * ELEMENTS_PER_BOARD;

   localparam int ELEM_IDX_W = $clog2(NUM_ELEMENTS);
   localparam int COUNT_W    = $clog2(FRAME_BUFFER_BYTES + 1);
   localparam int FB_IDX_W   = $clog2(FRAME_BUFFER_BYTES);

   // Field widths
   localparam int FUNC_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 5;
   localparam int SAMPLE_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int TICK_W      = 10;
   localparam int TIME_W      = 16;
   localparam int ELAPSED_W   = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BYTE_W-1:0]          END_MARK        = 8'hFF;
   localparam int                         SAMPLE_HI_SHIFT = 7;
   localparam logic signed [SAMPLE_W-1:0] NO_SAMPLE       = -16'sd1;
   localparam logic [ELAPSED_W-1:0]       ELAPSED_MAX     = {ELAPSED_W{1'b1}};

   // Reset values of the configuration registers
   localparam logic [TICK_W-1:0] TICK_MS_RESET      = 10'd10;
   localparam logic [TIME_W-1:0] INIT_TEST_RESET    = 16'd1000;
   localparam logic [TIME_W-1:0] SILENCE_LIMIT_RESET = 16'd500;

   // Item kinds on the request side
   localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_MS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_TEST_MS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_LIMIT = 2'd3;

   // Link status codes as reported
   localparam logic [STATUS_W-1:0] LINK_DISABLED = 2'd0;
   localparam logic [STATUS_W-1:0] LINK_WAITING  = 2'd1;
   localparam logic [STATUS_W-1:0] LINK_ACTIVE   = 2'd2;

   // Queues between the parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_DISABLED = 3'b001,
      ST_WAITING  = 3'b010,
      ST_ACTIVE   = 3'b100
   } status_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_TICK,
      KIND_READ,
      KIND_IDLE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic                end_mark;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  element_index;
   } item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [STATUS_W-1:0]        link_status;
      logic                       fresh_flag;
   } result_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   function automatic logic [QPTR_W-1:0] next_qptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- src/sfp_front.sv -----
`default_nettype none

module sfp_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   output logic                         full,
   input  wire [sfp_pkg::FUNC_W-1:0]    func,
   input  wire [sfp_pkg::BYTE_W-1:0]    rx_byte,
   input  wire [sfp_pkg::INDEX_W-1:0]   element_index,
   output logic                         item_valid,
   output sfp_pkg::item_type            item,
   input  wire                          item_take
);

   sfp_pkg::item_type             queue_ff [sfp_pkg::QUEUE_DEPTH];
   sfp_pkg::item_type             incoming;
   logic [sfp_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sfp_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sfp_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push, do_pop;

   // Classify the item on the way in
   always_comb begin
      incoming.rx_byte       = rx_byte;
      incoming.element_index = element_index;
      incoming.end_mark      = (rx_byte == sfp_pkg::END_MARK);
      case (func)
         sfp_pkg::FUNC_BYTE: incoming.kind = sfp_pkg::KIND_BYTE;
         sfp_pkg::FUNC_TICK: incoming.kind = sfp_pkg::KIND_TICK;
         sfp_pkg::FUNC_READ: incoming.kind = sfp_pkg::KIND_READ;
         default:            incoming.kind = sfp_pkg::KIND_IDLE;
      endcase
   end

   assign full       = (count_ff == sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? sfp_pkg::next_qptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? sfp_pkg::next_qptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

   a_fill_tracks_transfers: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !item_take) |=> (count_ff == sfp_pkg::QCNT_W'($past(count_ff) + 1'b1)))
      else $error("front queue count lost a transfer");

endmodule

`default_nettype wire

// ----- src/sfp_exec.sv -----
`default_nettype none

module sfp_exec (
   input  wire                    clock,
   input  wire                    reset,
   input  sfp_pkg::csr_write_type csr,
   input  wire                    item_valid,
   input  sfp_pkg::item_type      item,
   output logic                   item_take,
   input  wire                    rsp_full,
   output logic                   rsp_push,
   output sfp_pkg::result_type    rsp_result
);

   localparam int NE = sfp_pkg::NUM_ELEMENTS;
   localparam int EB = sfp_pkg::ELEMENTS_PER_BOARD;
   localparam int FB = sfp_pkg::FRAME_BUFFER_BYTES;

   sfp_pkg::status_type                   status_ff, status_in;
   logic [sfp_pkg::ELAPSED_W-1:0]         elapsed_ff, elapsed_in;
   logic [sfp_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic                                  fresh_ff, fresh_in;
   logic [NE-1:0]                         valid_ff, valid_in;
   logic [sfp_pkg::TICK_W-1:0]            tick_ff, tick_in;
   logic [sfp_pkg::TIME_W-1:0]            init_ff, init_in;
   logic [sfp_pkg::TIME_W-1:0]            silence_ff, silence_in;
   logic [sfp_pkg::BYTE_W-1:0]            frame_ff [FB];
   logic signed [sfp_pkg::SAMPLE_W-1:0]   sample_ff [NE];

   logic signed [sfp_pkg::SAMPLE_W-1:0]   frame_sample [EB];
   logic [NE-1:0]                         board_hit;
   logic [sfp_pkg::BYTE_W-1:0]            board_byte, board_idx;
   logic                                  board_ok, len_ok, window_open;
   logic                                  exec_go, frame_ok, byte_wr;
   logic [sfp_pkg::ELAPSED_W:0]           elapsed_sum;
   logic [sfp_pkg::ELAPSED_W-1:0]         elapsed_sat;
   logic [sfp_pkg::ELEM_IDX_W-1:0]        rev_idx;
   logic                                  idx_ok;
   logic signed [sfp_pkg::SAMPLE_W-1:0]   store_rd, read_sample;
   logic                                  fresh_out;
   logic [sfp_pkg::STATUS_W-1:0]          link_code;

   // Hold the item while a register write is being taken or the result queue is full
   assign exec_go   = item_valid && !rsp_full && !csr.valid;
   assign item_take = exec_go;
   assign rsp_push  = exec_go;

   assign board_byte = frame_ff[0];
   assign board_idx  = board_byte - 1'b1;
   assign board_ok   = (board_byte != '0)
                    && (board_byte <= sfp_pkg::BYTE_W'(sfp_pkg::NUM_BOARDS));
   assign len_ok     = (sfp_pkg::FRAME_LEN <= FB)
                    && (count_ff == sfp_pkg::COUNT_W'(sfp_pkg::FRAME_LEN));
   assign window_open = (status_ff == sfp_pkg::ST_ACTIVE)
                     || ((status_ff == sfp_pkg::ST_WAITING)
                         && (elapsed_ff < sfp_pkg::ELAPSED_W'(init_ff)));

   // One sample per byte pair of the buffered frame
   for (genvar k = 0; k < EB; k++) begin : g_pair
      localparam logic [sfp_pkg::FB_IDX_W-1:0] HI_POS =
         sfp_pkg::FB_IDX_W'((2 * k + 1) % FB);
      localparam logic [sfp_pkg::FB_IDX_W-1:0] LO_POS =
         sfp_pkg::FB_IDX_W'((2 * k + 2) % FB);
      assign frame_sample[k] =
         (sfp_pkg::SAMPLE_W'(frame_ff[HI_POS]) << sfp_pkg::SAMPLE_HI_SHIFT)
         + sfp_pkg::SAMPLE_W'(frame_ff[LO_POS]);
   end

   for (genvar e = 0; e < NE; e++) begin : g_elem
      localparam int K = e % EB;
      assign board_hit[e] = (board_idx == sfp_pkg::BYTE_W'(e / EB));
      always_ff @(posedge clock) begin
         if (frame_ok && board_hit[e]) begin
            sample_ff[e] <= frame_sample[K];
         end
      end
   end

   assign elapsed_sum = (sfp_pkg::ELAPSED_W + 1)'(elapsed_ff)
                      + (sfp_pkg::ELAPSED_W + 1)'(tick_ff);
   assign elapsed_sat = (elapsed_sum > (sfp_pkg::ELAPSED_W + 1)'(sfp_pkg::ELAPSED_MAX))
                      ? sfp_pkg::ELAPSED_MAX : elapsed_sum[sfp_pkg::ELAPSED_W-1:0];

   // Element 0 is the tip, the last entry of the store
   assign rev_idx  = sfp_pkg::ELEM_IDX_W'(NE - 1 - int'(item.element_index));
   assign idx_ok   = int'(item.element_index) < NE;
   assign store_rd = valid_ff[rev_idx] ? sample_ff[rev_idx] : sfp_pkg::NO_SAMPLE;

   always_comb begin
      status_in   = status_ff;
      elapsed_in  = elapsed_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      valid_in    = valid_ff;
      tick_in     = tick_ff;
      init_in     = init_ff;
      silence_in  = silence_ff;
      frame_ok    = 1'b0;
      byte_wr     = 1'b0;
      read_sample = '0;
      if (csr.valid) begin
         case (csr.index)
            sfp_pkg::CSR_LINK_ENABLE: begin
               status_in  = csr.data[0] ? sfp_pkg::ST_WAITING : sfp_pkg::ST_DISABLED;
               elapsed_in = '0;
               count_in   = '0;
               fresh_in   = 1'b0;
               valid_in   = '0;
            end
            sfp_pkg::CSR_TICK_MS:       tick_in    = csr.data[sfp_pkg::TICK_W-1:0];
            sfp_pkg::CSR_INIT_TEST_MS:  init_in    = csr.data[sfp_pkg::TIME_W-1:0];
            sfp_pkg::CSR_SILENCE_LIMIT: silence_in = csr.data[sfp_pkg::TIME_W-1:0];
            default: ;
         endcase
      end else if (exec_go) begin
         case (item.kind)
            sfp_pkg::KIND_BYTE: begin
               if (status_ff != sfp_pkg::ST_DISABLED) begin
                  if (!item.end_mark) begin
                     // Drop bytes once the buffer is full
                     if (count_ff < sfp_pkg::COUNT_W'(FB)) begin
                        byte_wr  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end else begin
                     count_in = '0;
                     if (window_open && len_ok && board_ok) begin
                        frame_ok   = 1'b1;
                        elapsed_in = '0;
                        status_in  = sfp_pkg::ST_ACTIVE;
                        valid_in   = valid_ff | board_hit;
                        if (board_idx == sfp_pkg::BYTE_W'(sfp_pkg::NUM_BOARDS - 1)) begin
                           fresh_in = 1'b1;
                        end
                     end
                  end
               end
            end
            sfp_pkg::KIND_TICK: begin
               if (status_ff == sfp_pkg::ST_DISABLED) begin
                  elapsed_in = '0;
                  count_in   = '0;
                  fresh_in   = 1'b0;
                  valid_in   = '0;
               end else if (((status_ff == sfp_pkg::ST_WAITING)
                             && (elapsed_sat > sfp_pkg::ELAPSED_W'(init_ff)))
                         || ((status_ff == sfp_pkg::ST_ACTIVE)
                             && (elapsed_sat > sfp_pkg::ELAPSED_W'(silence_ff)))) begin
                  // Watchdog expired: re-arm and forget every sample
                  status_in  = sfp_pkg::ST_WAITING;
                  elapsed_in = '0;
                  count_in   = '0;
                  fresh_in   = 1'b0;
                  valid_in   = '0;
               end else begin
                  elapsed_in = elapsed_sat;
               end
            end
            sfp_pkg::KIND_READ: begin
               fresh_in = 1'b0;
               if ((status_ff == sfp_pkg::ST_ACTIVE) && idx_ok) begin
                  read_sample = store_rd;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (status_in)
         sfp_pkg::ST_WAITING: link_code = sfp_pkg::LINK_WAITING;
         sfp_pkg::ST_ACTIVE:  link_code = sfp_pkg::LINK_ACTIVE;
         default:             link_code = sfp_pkg::LINK_DISABLED;
      endcase
   end

   assign fresh_out = (item.kind == sfp_pkg::KIND_READ) ? fresh_ff : fresh_in;

   always_comb begin
      rsp_result.sample_value = read_sample;
      rsp_result.link_status  = link_code;
      rsp_result.fresh_flag   = fresh_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= sfp_pkg::ST_DISABLED;
         elapsed_ff <= '0;
         count_ff   <= '0;
         fresh_ff   <= 1'b0;
         valid_ff   <= '0;
         tick_ff    <= sfp_pkg::TICK_MS_RESET;
         init_ff    <= sfp_pkg::INIT_TEST_RESET;
         silence_ff <= sfp_pkg::SILENCE_LIMIT_RESET;
      end else begin
         status_ff  <= status_in;
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
         fresh_ff   <= fresh_in;
         valid_ff   <= valid_in;
         tick_ff    <= tick_in;
         init_ff    <= init_in;
         silence_ff <= silence_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_wr) begin
         frame_ff[count_ff[sfp_pkg::FB_IDX_W-1:0]] <= item.rx_byte;
      end
   end

   a_disabled_is_clear: assert property (@(posedge clock) disable iff (reset)
      (status_ff == sfp_pkg::ST_DISABLED)
         |-> (count_ff == '0 && !fresh_ff && valid_ff == '0))
      else $error("state left behind while link disabled");

   a_fresh_only_active: assert property (@(posedge clock) disable iff (reset)
      fresh_ff |-> (status_ff == sfp_pkg::ST_ACTIVE))
      else $error("fresh flag set without an active link");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> (count_ff <= sfp_pkg::COUNT_W'(FB)))
      else $error("frame buffer count beyond its depth");

endmodule

`default_nettype wire

// ----- src/sfp_rsp_queue.sv -----
`default_nettype none

module sfp_rsp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  sfp_pkg::result_type push_result,
   output logic                full,
   output logic                empty,
   input  wire                 pop,
   output sfp_pkg::result_type head
);

   sfp_pkg::result_type           queue_ff [sfp_pkg::QUEUE_DEPTH];
   logic [sfp_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sfp_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sfp_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push, do_pop;

   assign full    = (count_ff == sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = queue_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? sfp_pkg::next_qptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? sfp_pkg::next_qptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_result;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// ----- src/sensor_frame_parser_with_watchdog_core.sv -----
`default_nettype none

// Sensor frame parser with watchdog. Each item (received byte, timer tick or
// element read) gives exactly one result, in order. A new item is taken in every
// cycle unless the result queue is full or a register write is taken: all state
// (link status, elapsed time, frame buffer, sample store) is updated by a single
// execute stage, and a frame end writes a whole board of samples at once. A
// pushed item is registered in the request queue and its result in the response
// queue, from which it is popped; two-entry queues on either side of the execute
// stage absorb stalls. csr_ready is always high; a register write holds the
// execute stage for that cycle. Writing link_enable clears the block in the same
// cycle, with no clearing pass.
module sensor_frame_parser_with_watchdog_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 push,
   output logic                                full,
   input  wire [sfp_pkg::FUNC_W-1:0]           req_func,
   input  wire [sfp_pkg::BYTE_W-1:0]           req_rx_byte,
   input  wire [sfp_pkg::INDEX_W-1:0]          req_element_index,
   output logic                                empty,
   input  wire                                 pop,
   output logic signed [sfp_pkg::SAMPLE_W-1:0] rsp_sample_value,
   output logic [sfp_pkg::STATUS_W-1:0]        rsp_link_status,
   output logic                                rsp_fresh_flag,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [sfp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [sfp_pkg::CSR_DATA_W-1:0]       csr_data
);

   sfp_pkg::item_type      item;
   sfp_pkg::result_type    result, head;
   sfp_pkg::csr_write_type csr_write;
   logic                   item_valid, item_take;
   logic                   rsp_push, rsp_full;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_write.valid = csr_valid;
      csr_write.index = csr_index;
      csr_write.data  = csr_data;
   end

   sfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .func          (req_func),
      .rx_byte       (req_rx_byte),
      .element_index (req_element_index),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   sfp_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_write),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_result (result)
   );

   sfp_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (rsp_push),
      .push_result (result),
      .full        (rsp_full),
      .empty       (empty),
      .pop         (pop),
      .head        (head)
   );

   assign rsp_sample_value = head.sample_value;
   assign rsp_link_status  = head.link_status;
   assign rsp_fresh_flag   = head.fresh_flag;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

   localparam logic [sfp_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 8;
   // hi/lo pairs of the directed frame, element 0 last
   localparam logic [127:0] DIRECTED_PAIRS = 128'hFEFE_0000_7F01_017F_55AA_AA55_8000_1234;

   typedef struct packed {
      logic [sfp_pkg::FUNC_W-1:0]  func;
      logic [sfp_pkg::BYTE_W-1:0]  rx;
      logic [sfp_pkg::INDEX_W-1:0] idx;
   } sensor_item_type;

   typedef struct {
      bit                              is_csr;
      logic [sfp_pkg::CSR_INDEX_W-1:0] reg_index;
      logic [sfp_pkg::CSR_DATA_W-1:0]  reg_data;
      sensor_item_type                 item;
      bit                              typed;
      sfp_pkg::result_type             want;
   } dir_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                push = 1'b0;
   logic                                full;
   logic [sfp_pkg::FUNC_W-1:0]          req_func = '0;
   logic [sfp_pkg::BYTE_W-1:0]          req_rx_byte = '0;
   logic [sfp_pkg::INDEX_W-1:0]         req_element_index = '0;
   logic                                empty;
   logic                                pop = 1'b0;
   logic signed [sfp_pkg::SAMPLE_W-1:0] rsp_sample_value;
   logic [sfp_pkg::STATUS_W-1:0]        rsp_link_status;
   logic                                rsp_fresh_flag;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [sfp_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [sfp_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   sensor_frame_parser_with_watchdog_core dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_rx_byte       (req_rx_byte),
      .req_element_index (req_element_index),
      .empty             (empty),
      .pop               (pop),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_link_status   (rsp_link_status),
      .rsp_fresh_flag    (rsp_fresh_flag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser state as the block should hold it
   logic [sfp_pkg::STATUS_W-1:0]        link_state;
   logic [sfp_pkg::ELAPSED_W-1:0]       elapsed;
   int                                  rx_count;
   logic [sfp_pkg::BYTE_W-1:0]          rx_buf [sfp_pkg::FRAME_BUFFER_BYTES];
   logic signed [sfp_pkg::SAMPLE_W-1:0] samples [sfp_pkg::NUM_ELEMENTS];
   logic                                fresh;
   logic [sfp_pkg::TICK_W-1:0]          cfg_tick;
   logic [sfp_pkg::TIME_W-1:0]          cfg_init_test;
   logic [sfp_pkg::TIME_W-1:0]          cfg_silence;

   sfp_pkg::result_type expected_results[$];
   sensor_item_type     next_burst[$];
   int                  fail_count = 0;
   int                  sender_pct = 0;
   int                  stall_pct = 0;
   int                  hold_requests = 0;
   int                  holds_served = 0;
   int                  hold_left = 0;

   function automatic void clear_link(input logic on);
      fresh = 1'b0;
      elapsed = '0;
      rx_count = 0;
      for (int k = 0; k < sfp_pkg::NUM_ELEMENTS; k++) begin
         samples[k] = sfp_pkg::NO_SAMPLE;
      end
      link_state = on ? sfp_pkg::LINK_WAITING : sfp_pkg::LINK_DISABLED;
   endfunction

   function automatic void apply_reg_write(input logic [sfp_pkg::CSR_INDEX_W-1:0] idx,
                                           input logic [sfp_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         sfp_pkg::CSR_LINK_ENABLE: begin
            // any write clears, even of the same value
            clear_link(data[0]);
         end
         sfp_pkg::CSR_TICK_MS: begin
            cfg_tick = data[sfp_pkg::TICK_W-1:0];
         end
         sfp_pkg::CSR_INIT_TEST_MS: begin
            cfg_init_test = data;
         end
         sfp_pkg::CSR_SILENCE_LIMIT: begin
            cfg_silence = data;
         end
         default: ;
      endcase
   endfunction

   function automatic sfp_pkg::result_type parse_item(input sensor_item_type it);
      sfp_pkg::result_type         res;
      int                          board;
      logic [sfp_pkg::ELAPSED_W:0] sum;
      res.sample_value = '0;
      res.fresh_flag = 1'b0;
      case (it.func)
         sfp_pkg::FUNC_BYTE: begin
            if (link_state == sfp_pkg::LINK_DISABLED) begin
               // ignore bytes until enabled
            end else if (it.rx != sfp_pkg::END_MARK) begin
               // drop bytes once the buffer is full
               if (rx_count < sfp_pkg::FRAME_BUFFER_BYTES) begin
                  rx_buf[rx_count] = it.rx;
                  rx_count++;
               end
            end else begin
               if ((link_state == sfp_pkg::LINK_ACTIVE ||
                    (link_state == sfp_pkg::LINK_WAITING && elapsed < cfg_init_test)) &&
                   rx_count == sfp_pkg::FRAME_LEN) begin
                  board = rx_buf[0];
                  if (board >= 1 && board <= sfp_pkg::NUM_BOARDS) begin
                     if (board == sfp_pkg::NUM_BOARDS) begin
                        fresh = 1'b1;
                     end
                     for (int k = 0; k < sfp_pkg::ELEMENTS_PER_BOARD; k++) begin
                        samples[(board - 1) * sfp_pkg::ELEMENTS_PER_BOARD + k] =
                           (sfp_pkg::SAMPLE_W'(rx_buf[2 * k + 1]) << sfp_pkg::SAMPLE_HI_SHIFT)
                           + sfp_pkg::SAMPLE_W'(rx_buf[2 * k + 2]);
                     end
                     elapsed = '0;
                     link_state = sfp_pkg::LINK_ACTIVE;
                  end
               end
               rx_count = 0;
            end
         end
         sfp_pkg::FUNC_TICK: begin
            if (link_state == sfp_pkg::LINK_DISABLED) begin
               clear_link(1'b0);
            end else begin
               sum = elapsed + cfg_tick;
               elapsed = (sum > sfp_pkg::ELAPSED_MAX) ? sfp_pkg::ELAPSED_MAX
                                                      : sum[sfp_pkg::ELAPSED_W-1:0];
               if ((link_state == sfp_pkg::LINK_WAITING && elapsed > cfg_init_test) ||
                   (link_state == sfp_pkg::LINK_ACTIVE && elapsed > cfg_silence)) begin
                  // watchdog fired: re-arm and forget every sample
                  clear_link(1'b1);
               end
            end
         end
         sfp_pkg::FUNC_READ: begin
            res.fresh_flag = fresh;
            fresh = 1'b0;
            if (link_state == sfp_pkg::LINK_ACTIVE && it.idx < sfp_pkg::NUM_ELEMENTS) begin
               res.sample_value = samples[sfp_pkg::NUM_ELEMENTS - 1 - it.idx];
            end
         end
         default: ;
      endcase
      res.link_status = link_state;
      if (it.func != sfp_pkg::FUNC_READ) begin
         res.fresh_flag = fresh;
      end
      return res;
   endfunction

   function automatic sensor_item_type mk_item(input logic [sfp_pkg::FUNC_W-1:0] f,
                                               input logic [sfp_pkg::BYTE_W-1:0] b,
                                               input logic [sfp_pkg::INDEX_W-1:0] ix);
      sensor_item_type it;
      it.func = f;
      it.rx = b;
      it.idx = ix;
      return it;
   endfunction

   function automatic dir_row_type item_row(input sensor_item_type it);
      dir_row_type r;
      r.is_csr = 1'b0;
      r.reg_index = '0;
      r.reg_data = '0;
      r.item = it;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic dir_row_type checked_row(input sensor_item_type it,
                                               input logic signed [sfp_pkg::SAMPLE_W-1:0] s,
                                               input logic [sfp_pkg::STATUS_W-1:0] st,
                                               input logic fr);
      dir_row_type r;
      r = item_row(it);
      r.typed = 1'b1;
      r.want.sample_value = s;
      r.want.link_status = st;
      r.want.fresh_flag = fr;
      return r;
   endfunction

   function automatic dir_row_type csr_row(input logic [sfp_pkg::CSR_INDEX_W-1:0] idx,
                                           input logic [sfp_pkg::CSR_DATA_W-1:0] data);
      dir_row_type r;
      r = item_row('0);
      r.is_csr = 1'b1;
      r.reg_index = idx;
      r.reg_data = data;
      return r;
   endfunction

   function automatic logic [sfp_pkg::BYTE_W-1:0] data_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFE;
         default: return 8'($urandom_range(0, 254));
      endcase
   endfunction

   // Offer one item, then predict it once the transfer has happened
   task automatic send_item(input sensor_item_type it, input bit typed,
                            input sfp_pkg::result_type typed_res);
      sfp_pkg::result_type predicted;
      while ($urandom_range(0, 99) < sender_pct) begin
         @(negedge clock);
         push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      push <= 1'b1;
      req_func <= it.func;
      req_rx_byte <= it.rx;
      req_element_index <= it.idx;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      predicted = parse_item(it);
      expected_results.push_back(typed ? typed_res : predicted);
   endtask

   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [sfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sfp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_reg_write(idx, data);
   endtask

   task automatic plan_burst();
      int pick;
      int n;
      next_burst.delete();
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         // well-formed frame; some carry a board byte that no board answers to
         if (pick < 50) begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE,
               8'($urandom_range(1, sfp_pkg::NUM_BOARDS)), 5'($urandom)));
         end else begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE,
               ($urandom_range(0, 1) == 0) ? 8'h00
                  : 8'($urandom_range(sfp_pkg::NUM_BOARDS + 1, 254)),
               5'($urandom)));
         end
         for (int k = 0; k < sfp_pkg::FRAME_LEN - 1; k++) begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE, data_byte(), 5'($urandom)));
         end
         next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE, sfp_pkg::END_MARK, 5'($urandom)));
      end else if (pick < 66) begin
         // frame of the wrong length, running past the buffer at times
         n = $urandom_range(0, 32);
         if (n == sfp_pkg::FRAME_LEN) begin
            n = sfp_pkg::FRAME_LEN - 1;
         end
         for (int k = 0; k < n; k++) begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE,
               (k == 0) ? 8'($urandom_range(1, sfp_pkg::NUM_BOARDS)) : data_byte(),
               5'($urandom)));
         end
         next_burst.push_back(mk_item(sfp_pkg::FUNC_BYTE, sfp_pkg::END_MARK, 5'($urandom)));
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_TICK, 8'($urandom), 5'($urandom)));
         end
      end else if (pick < 95) begin
         repeat ($urandom_range(1, 3)) begin
            next_burst.push_back(mk_item(sfp_pkg::FUNC_READ, 8'($urandom),
               ($urandom_range(0, 3) == 0) ? 5'd31 : 5'($urandom_range(0, 31))));
         end
      end else begin
         next_burst.push_back(mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                      5'($urandom_range(0, 31))));
      end
   endtask

   task automatic run_phase(input logic en, input logic [sfp_pkg::TICK_W-1:0] tick,
                            input logic [sfp_pkg::TIME_W-1:0] init_ms,
                            input logic [sfp_pkg::TIME_W-1:0] silence_ms,
                            input int s_pct, input int r_pct, input bit long_hold,
                            input int n_items);
      int sent;
      settle();
      write_reg(sfp_pkg::CSR_LINK_ENABLE, 16'(en) | (16'($urandom_range(0, 32767)) << 1));
      write_reg(sfp_pkg::CSR_TICK_MS,
                16'(tick) | (16'($urandom_range(0, 63)) << sfp_pkg::TICK_W));
      write_reg(sfp_pkg::CSR_INIT_TEST_MS, init_ms);
      write_reg(sfp_pkg::CSR_SILENCE_LIMIT, silence_ms);
      @(negedge clock);
      csr_valid <= 1'b0;
      sender_pct = s_pct;
      stall_pct = r_pct;
      if (long_hold) begin
         hold_requests++;
      end
      sent = 0;
      while (sent < n_items) begin
         plan_burst();
         foreach (next_burst[k]) begin
            send_item(next_burst[k], 1'b0, '0);
         end
         sent += next_burst.size();
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      sfp_pkg::result_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: sample %0d status %0d fresh %0d",
                     $time, rsp_sample_value, rsp_link_status, rsp_fresh_flag);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_sample_value !== want.sample_value) begin
               $display("%0t: sample_value expected %0d got %0d",
                        $time, want.sample_value, rsp_sample_value);
               fail_count++;
            end
            if (rsp_link_status !== want.link_status) begin
               $display("%0t: link_status expected %0d got %0d",
                        $time, want.link_status, rsp_link_status);
               fail_count++;
            end
            if (rsp_fresh_flag !== want.fresh_flag) begin
               $display("%0t: fresh_flag expected %0d got %0d",
                        $time, want.fresh_flag, rsp_fresh_flag);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      dir_row_type directed[$];
      cfg_tick = sfp_pkg::TICK_MS_RESET;
      cfg_init_test = sfp_pkg::INIT_TEST_RESET;
      cfg_silence = sfp_pkg::SILENCE_LIMIT_RESET;
      for (int k = 0; k < sfp_pkg::FRAME_BUFFER_BYTES; k++) begin
         rx_buf[k] = '0;
      end
      clear_link(1'b0);

      // disabled: bytes dropped, tick clears, unused code changes nothing
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_READ, 8'h00, 5'd31), '0,
                                     sfp_pkg::LINK_DISABLED, 1'b0));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_BYTE, 8'h5A, 5'd0), '0,
                                     sfp_pkg::LINK_DISABLED, 1'b0));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_TICK, 8'h00, 5'd0), '0,
                                     sfp_pkg::LINK_DISABLED, 1'b0));
      directed.push_back(checked_row(mk_item(FUNC_NOP, 8'hFF, 5'd31), '0,
                                     sfp_pkg::LINK_DISABLED, 1'b0));
      directed.push_back(csr_row(sfp_pkg::CSR_LINK_ENABLE, 16'h0001));
      // frame far too short: discarded
      directed.push_back(item_row(mk_item(sfp_pkg::FUNC_BYTE, 8'h04, 5'd0)));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_BYTE, sfp_pkg::END_MARK, 5'd0), '0,
                                     sfp_pkg::LINK_WAITING, 1'b0));
      // good frame for the last board
      directed.push_back(item_row(mk_item(sfp_pkg::FUNC_BYTE, 8'h04, 5'd0)));
      for (int k = 0; k < sfp_pkg::FRAME_LEN - 1; k++) begin
         directed.push_back(item_row(mk_item(sfp_pkg::FUNC_BYTE,
                                             DIRECTED_PAIRS[127 - 8 * k -: 8], 5'd0)));
      end
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_BYTE, sfp_pkg::END_MARK, 5'd0), '0,
                                     sfp_pkg::LINK_ACTIVE, 1'b1));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_READ, 8'h00, 5'd0), 16'sd2356,
                                     sfp_pkg::LINK_ACTIVE, 1'b1));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_READ, 8'h00, 5'd7), 16'sd32766,
                                     sfp_pkg::LINK_ACTIVE, 1'b0));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_READ, 8'h00, 5'd24),
                                     sfp_pkg::NO_SAMPLE, sfp_pkg::LINK_ACTIVE, 1'b0));
      // zero silence allowance: the next tick times the link out
      directed.push_back(csr_row(sfp_pkg::CSR_SILENCE_LIMIT, 16'h0000));
      directed.push_back(checked_row(mk_item(sfp_pkg::FUNC_TICK, 8'h00, 5'd0), '0,
                                     sfp_pkg::LINK_WAITING, 1'b0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            settle();
            write_reg(directed[i].reg_index, directed[i].reg_data);
            @(negedge clock);
            csr_valid <= 1'b0;
         end else begin
            send_item(directed[i].item, directed[i].typed, directed[i].want);
         end
      end

      run_phase(1'b1, 10'd10, 16'd1000, 16'd500, 0, 0, 1'b0, 140);
      run_phase(1'b1, 10'd1, 16'd65535, 16'd65535, 49, 0, 1'b0, 140);
      run_phase(1'b1, 10'd250, 16'd3000, 16'd2000, 0, 49, 1'b1, 140);
      run_phase(1'b1, 10'd700, 16'd0, 16'd0, 9, 9, 1'b0, 80);
      run_phase(1'b0, 10'd37, 16'd400, 16'd250, 0, 0, 1'b0, 40);
      run_phase(1'b1, 10'd1000, 16'd65535, 16'd0, 9, 9, 1'b0, 140);

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
